### sv/cdet_pkg.sv
// ---------------------------------------------------------------------------
// cdet_pkg: shared types, constants and helpers for the colour-distance edge
// detector.
// ---------------------------------------------------------------------------
`default_nettype none

package cdet_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int CH_W      = 8;
    localparam int LINE_W    = 11;
    localparam int THR_W     = 18;
    localparam int DATA_W    = 18;
    localparam int DIST_W    = 18;

    localparam logic [LINE_W-1:0] LINE_WIDTH_RESET = 11'd1024;
    localparam logic [THR_W-1:0]  THRESHOLD_RESET  = 18'd16257;
    localparam logic [LINE_W-1:0] MAX_WIDTH_L      = LINE_W'(MAX_WIDTH);

    typedef enum logic [0:0] {
        REG_LINE_WIDTH = 1'b0,
        REG_THRESHOLD  = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [CH_W-1:0] r;
        logic [CH_W-1:0] g;
        logic [CH_W-1:0] b;
    } rgb_t;

    // flags that travel with a request down the pipe
    typedef struct packed {
        logic valid;
        logic has_above;
        logic has_left;
    } stage_flags_t;

    function automatic logic [2*CH_W-1:0] sq_diff(input logic [CH_W-1:0] a,
                                                  input logic [CH_W-1:0] b);
        logic [CH_W-1:0] d;
        d = (a > b) ? (a - b) : (b - a);
        return (2*CH_W)'(d) * (2*CH_W)'(d);
    endfunction

    function automatic logic [DIST_W-1:0] dist_sq(input rgb_t p, input rgb_t q);
        logic [DIST_W-1:0] sum;
        sum = DIST_W'(sq_diff(p.r, q.r)) + DIST_W'(sq_diff(p.g, q.g))
            + DIST_W'(sq_diff(p.b, q.b));
        return sum;
    endfunction

endpackage

`default_nettype wire

### sv/cdet_line_store.sv
// ---------------------------------------------------------------------------
// cdet_line_store: one-row pixel store
// Single port: read-old-data on a write to the same address, registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module cdet_line_store
    import cdet_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             access,
    input  wire logic [COL_W-1:0] addr,
    input  wire rgb_t             wdata,
    output rgb_t                  rdata
);

    rgb_t mem [MAX_WIDTH];
    rgb_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (access)
        begin
            rdata_reg <= mem[addr];
            mem[addr] <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### sv/cdet_dist_stage.sv
// ---------------------------------------------------------------------------
// cdet_dist_stage: squared RGB distance stage
// Registers the squared distances to the pixel above and to the left.
// ---------------------------------------------------------------------------
`default_nettype none

module cdet_dist_stage
    import cdet_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              advance,
    input  wire stage_flags_t      flags,
    input  wire rgb_t              pix,
    input  wire rgb_t              above,
    input  wire rgb_t              left,
    output stage_flags_t           flags_out,
    output logic [DIST_W-1:0]      dist_above,
    output logic [DIST_W-1:0]      dist_left
);

    stage_flags_t      flags_reg;
    logic [DIST_W-1:0] dist_above_reg;
    logic [DIST_W-1:0] dist_left_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flags_reg <= '0;
        end
        else if (advance)
        begin
            flags_reg <= flags;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            dist_above_reg <= dist_sq(pix, above);
            dist_left_reg  <= dist_sq(pix, left);
        end
    end

    assign flags_out  = flags_reg;
    assign dist_above = dist_above_reg;
    assign dist_left  = dist_left_reg;

endmodule

`default_nettype wire

### sv/color_distance_edge_detect_unit.sv
// ---------------------------------------------------------------------------
// color_distance_edge_detect_unit: colour-distance edge detector
// Flags a pixel when its squared RGB distance to the pixel above or to the
// left reaches the threshold.
// ---------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+--------------------------------
//  in       | in_valid/in_stall  | red, green, blue, frame_start
//  out      | out_valid/out_stall| is_edge
//  cfg      | cfg_write          | cfg_index, cfg_data
//
//  One pixel per cycle unless the output is stalled; a result passes through the
//  line-store read, the distance stage and the compare into the output register.
//  Each stage holds its request while the one after it is full and stalled.
//  Reset: top-left position, first row, registers at their default values.
// The line store is not cleared; its output is ignored for pixels of the first row.
// ---------------------------------------------------------------------------
`default_nettype none

module color_distance_edge_detect_unit
    import cdet_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_write,
    input  wire logic [0:0]        cfg_index,
    input  wire logic [DATA_W-1:0] cfg_data,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [CH_W-1:0]   red,
    input  wire logic [CH_W-1:0]   green,
    input  wire logic [CH_W-1:0]   blue,
    input  wire logic              frame_start,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic                   is_edge
);

    logic [LINE_W-1:0] line_width_reg;
    logic [THR_W-1:0]  threshold_reg;
    logic [COL_W-1:0]  column_reg;
    logic [COL_W-1:0]  column_next;
    logic              first_row_reg;
    logic              first_row_next;
    rgb_t              left_reg;
    rgb_t              pix;

    stage_flags_t      s1_flags_reg;
    stage_flags_t      s1_flags_next;
    rgb_t              s1_pix_reg;
    rgb_t              s1_left_reg;
    rgb_t              s1_above;

    stage_flags_t      s2_flags;
    logic [DIST_W-1:0] s2_dist_above;
    logic [DIST_W-1:0] s2_dist_left;

    logic              out_valid_reg;
    logic              edge_reg;
    logic              edge_next;

    logic              adv_out;
    logic              adv_s2;
    logic              adv_s1;
    logic              accept;

    logic [LINE_W-1:0] eff_width;
    logic [COL_W-1:0]  col;
    logic              first_row;
    logic [LINE_W-1:0] col_inc;
    logic              row_end;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_width_reg <= LINE_WIDTH_RESET;
            threshold_reg  <= THRESHOLD_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_LINE_WIDTH: line_width_reg <= cfg_data[LINE_W-1:0];
                REG_THRESHOLD:  threshold_reg  <= cfg_data[THR_W-1:0];
                default:        ;
            endcase
        end
    end

    // pipeline flow
    assign adv_out  = !out_valid_reg || !out_stall;
    assign adv_s2   = !s2_flags.valid || adv_out;
    assign adv_s1   = !s1_flags_reg.valid || adv_s2;
    assign in_stall = !adv_s1;
    assign accept   = in_valid && adv_s1;

    // raster position
    always_comb
    begin
        if (line_width_reg == '0)
            eff_width = LINE_W'(1);
        else if (line_width_reg > MAX_WIDTH_L)
            eff_width = MAX_WIDTH_L;
        else
            eff_width = line_width_reg;

        col       = frame_start ? '0 : column_reg;
        first_row = frame_start ? 1'b1 : first_row_reg;
        col_inc   = LINE_W'(col) + LINE_W'(1);
        row_end   = col_inc >= eff_width;

        column_next    = row_end ? '0 : col_inc[COL_W-1:0];
        first_row_next = row_end ? 1'b0 : first_row;

        s1_flags_next.valid     = in_valid;
        s1_flags_next.has_above = !first_row;
        s1_flags_next.has_left  = (col != '0);
    end

    assign pix = '{r: red, g: green, b: blue};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_reg    <= '0;
            first_row_reg <= 1'b1;
            left_reg      <= '0;
            s1_flags_reg  <= '0;
        end
        else
        begin
            if (accept)
            begin
                column_reg    <= column_next;
                first_row_reg <= first_row_next;
                left_reg      <= pix;
            end
            if (adv_s1)
            begin
                s1_flags_reg <= s1_flags_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg  <= pix;
            s1_left_reg <= left_reg;
        end
    end

    cdet_line_store u_line_store (
        .clk   (clk),
        .access(accept),
        .addr  (col),
        .wdata (pix),
        .rdata (s1_above)
    );

    cdet_dist_stage u_dist_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (adv_s2),
        .flags     (s1_flags_reg),
        .pix       (s1_pix_reg),
        .above     (s1_above),
        .left      (s1_left_reg),
        .flags_out (s2_flags),
        .dist_above(s2_dist_above),
        .dist_left (s2_dist_left)
    );

    // threshold compare into the output register
    assign edge_next = (s2_flags.has_above && (s2_dist_above >= threshold_reg))
                    || (s2_flags.has_left && (s2_dist_left >= threshold_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv_out)
        begin
            out_valid_reg <= s2_flags.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_out)
        begin
            edge_reg <= edge_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign is_edge   = edge_reg;

    // checks
    a_empty_out_never_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> !in_stall)
        else $error("input stalled with empty output register");

    a_accept_fills_s1: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_flags_reg.valid)
        else $error("accepted request lost before distance stage");

    a_s2_reaches_out: assert property (@(posedge clk) disable iff (!rst_n)
        (s2_flags.valid && adv_out) |=> out_valid_reg)
        else $error("distance result lost before output register");

    a_frame_start_column: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && frame_start && (eff_width != LINE_W'(1)))
            |=> (column_reg == COL_W'(1)) && first_row_reg)
        else $error("frame start did not restart the raster position");

endmodule

`default_nettype wire
